// File: src/command_apdu_case_checker_top_macros.svh
// Assertion macros for the command APDU case checker.
// Used by command_apdu_case_checker_top; expects clk and rst_n in scope.
`ifndef COMMAND_APDU_CASE_CHECKER_TOP_MACROS_SVH
`define COMMAND_APDU_CASE_CHECKER_TOP_MACROS_SVH

// condition must hold at every edge out of reset
`define APDUCC_ASSERT(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// antecedent at one edge implies consequent at the next
`define APDUCC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: src/apducc_pkg.sv
// Package for the command APDU case checker: widths, header constants,
// case and error codes. No dependencies.
package apducc_pkg;

    localparam int COUNT_W = 17;
    localparam int LE_W    = 17;

    typedef logic [COUNT_W-1:0] count_t;
    typedef logic [LE_W-1:0]    le_limit_t;
    typedef logic [2:0]         case_t;
    typedef logic [3:0]         err_t;

    localparam count_t    COUNT_MAX    = 17'h1FFFF;
    localparam le_limit_t MAX_LE_RESET = 17'h10000;

    localparam logic [7:0] CLA_INVALID = 8'hFF;
    localparam logic [7:0] INS_MASK    = 8'hF0;
    localparam logic [7:0] INS_PROC_6X = 8'h60;
    localparam logic [7:0] INS_PROC_9X = 8'h90;
    localparam logic [7:0] LEN_ZERO    = 8'h00;

    // byte offsets in the header
    localparam count_t POS_CLA = 17'd0;
    localparam count_t POS_INS = 17'd1;
    localparam count_t POS_P3  = 17'd4;
    localparam count_t POS_EXH = 17'd5;
    localparam count_t POS_EXL = 17'd6;

    // APDU lengths used by the case decision
    localparam count_t LEN_HDR     = 17'd4;
    localparam count_t LEN_SHORT   = 17'd5;
    localparam count_t LEN_SHORT_LE = 17'd6;
    localparam count_t LEN_EXT     = 17'd7;
    localparam count_t LEN_EXT_LE  = 17'd9;

    localparam case_t CASE_NONE = 3'd0;
    localparam case_t CASE_1    = 3'd1;
    localparam case_t CASE_2S   = 3'd2;
    localparam case_t CASE_3S   = 3'd3;
    localparam case_t CASE_4S   = 3'd4;
    localparam case_t CASE_2E   = 3'd5;
    localparam case_t CASE_3E   = 3'd6;
    localparam case_t CASE_4E   = 3'd7;

    localparam err_t ERR_OK      = 4'd0;
    localparam err_t ERR_SHORT   = 4'd1;
    localparam err_t ERR_CLA     = 4'd2;
    localparam err_t ERR_INS     = 4'd3;
    localparam err_t ERR_LE      = 4'd4;
    localparam err_t ERR_LC_SHORT = 4'd5;
    localparam err_t ERR_EXT_LEN = 4'd6;
    localparam err_t ERR_LC_ZERO = 4'd7;
    localparam err_t ERR_LC_EXT  = 4'd8;

endpackage

// File: src/command_apdu_case_checker_top.sv
// Command APDU case checker, top level.
// Depends on apducc_pkg and command_apdu_case_checker_top_macros.svh.
//
// Usage:
//   s_* stream: one APDU byte per transfer in s_tdata[7:0], s_tlast on the
//   final byte of the APDU. Bytes are counted (to 131071), header fields kept.
//   m_* stream: one verdict per APDU, issued for the transfer that carried
//   s_tlast. m_tdata holds the case, the error code and a valid flag.
//   cfg_*: write of max_expected_le (17 bits); cfg_ready is always high.
//   Write it only while no APDU is in progress.
//   The verdict is on m_tvalid in the cycle after the last byte is taken.
//   Throughput: one byte per cycle while s_tready is high; the byte count update and the length
//   compares sit between the input port and the result register.
//   When the receiver stalls, the verdict is held in the result register
//   and s_tready drops only while that register is full and not taken.
//   Reset clears the byte count, header bytes and the result valid flag and
//   sets max_expected_le to 65536.
module command_apdu_case_checker_top
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] apdu_byte
    input  logic        s_tlast,   // is_last
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [2:0] apdu_case, [6:3] error_code, [7] is_valid
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [16:0] cfg_data   // max_expected_le
);
    import apducc_pkg::*;

    count_t     count_reg, count_next;
    logic [7:0] cla_reg, cla_next;
    logic [7:0] ins_reg, ins_next;
    logic [7:0] p3_reg, p3_next;
    logic [7:0] exh_reg, exh_next;
    logic [7:0] exl_reg, exl_next;
    logic [7:0] prev_reg, prev_next;
    le_limit_t  max_le_reg;
    logic       out_valid_reg, out_valid_next;
    logic [7:0] out_data_reg, out_data_next;

    logic        in_xfer;
    logic [7:0]  b;
    count_t      n;
    logic [7:0]  cla_eff, ins_eff, p3_eff, exh_eff, exl_eff;
    logic [15:0] ext_lc;
    case_t       kind;
    err_t        err;
    logic [15:0] le;
    logic        need_le;

    assign cfg_ready = 1'b1;
    assign s_tready  = !out_valid_reg || m_tready;
    assign in_xfer   = s_tvalid && s_tready;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = out_data_reg;

    assign b       = s_tdata;
    assign n       = (count_reg == COUNT_MAX) ? COUNT_MAX : count_reg + 17'd1;
    assign cla_eff = (count_reg == POS_CLA) ? b : cla_reg;
    assign ins_eff = (count_reg == POS_INS) ? b : ins_reg;
    assign p3_eff  = (count_reg == POS_P3)  ? b : p3_reg;
    assign exh_eff = (count_reg == POS_EXH) ? b : exh_reg;
    assign exl_eff = (count_reg == POS_EXL) ? b : exl_reg;
    assign ext_lc  = {exh_eff, exl_eff};

    always_comb
    begin
        kind    = CASE_NONE;
        err     = ERR_OK;
        le      = '0;
        need_le = 1'b0;
        priority if (n < LEN_HDR)
        begin
            err = ERR_SHORT;
        end
        else if (cla_eff == CLA_INVALID)
        begin
            err = ERR_CLA;
        end
        else if ((ins_eff & INS_MASK) == INS_PROC_6X || (ins_eff & INS_MASK) == INS_PROC_9X)
        begin
            err = ERR_INS;
        end
        else if (n == LEN_HDR)
        begin
            kind = CASE_1;
        end
        else if (n == LEN_SHORT)
        begin
            kind    = CASE_2S;
            le      = {8'h00, p3_eff};
            need_le = 1'b1;
        end
        else if (p3_eff != LEN_ZERO)
        begin
            priority if (n == LEN_SHORT + count_t'(p3_eff))
            begin
                kind = CASE_3S;
            end
            else if (n == LEN_SHORT_LE + count_t'(p3_eff))
            begin
                kind    = CASE_4S;
                le      = {8'h00, b};
                need_le = 1'b1;
            end
            else
            begin
                err = ERR_LC_SHORT;
            end
        end
        else if (n == LEN_EXT)
        begin
            kind    = CASE_2E;
            le      = ext_lc;
            need_le = 1'b1;
        end
        else if (n < LEN_EXT)
        begin
            err = ERR_EXT_LEN;
        end
        else if (ext_lc == 16'h0000)
        begin
            err = ERR_LC_ZERO;
        end
        else if (n == LEN_EXT + count_t'(ext_lc))
        begin
            kind = CASE_3E;
        end
        else if (n == LEN_EXT_LE + count_t'(ext_lc))
        begin
            kind    = CASE_4E;
            le      = {prev_reg, b};
            need_le = 1'b1;
        end
        else
        begin
            err = ERR_LC_EXT;
        end
        if (need_le && (le_limit_t'(le) > max_le_reg))
        begin
            kind = CASE_NONE;
            err  = ERR_LE;
        end
    end

    always_comb
    begin
        count_next     = count_reg;
        cla_next       = cla_reg;
        ins_next       = ins_reg;
        p3_next        = p3_reg;
        exh_next       = exh_reg;
        exl_next       = exl_reg;
        prev_next      = prev_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_data_next  = out_data_reg;
        if (in_xfer)
        begin
            if (s_tlast)
            begin
                count_next     = '0;
                cla_next       = '0;
                ins_next       = '0;
                p3_next        = '0;
                exh_next       = '0;
                exl_next       = '0;
                prev_next      = '0;
                out_valid_next = 1'b1;
                out_data_next  = {(err == ERR_OK), err, kind};
            end
            else
            begin
                count_next = n;
                cla_next   = cla_eff;
                ins_next   = ins_eff;
                p3_next    = p3_eff;
                exh_next   = exh_eff;
                exl_next   = exl_eff;
                prev_next  = b;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            cla_reg       <= '0;
            ins_reg       <= '0;
            p3_reg        <= '0;
            exh_reg       <= '0;
            exl_reg       <= '0;
            prev_reg      <= '0;
            max_le_reg    <= MAX_LE_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            cla_reg       <= cla_next;
            ins_reg       <= ins_next;
            p3_reg        <= p3_next;
            exh_reg       <= exh_next;
            exl_reg       <= exl_next;
            prev_reg      <= prev_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                max_le_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

`include "command_apdu_case_checker_top_macros.svh"

    `APDUCC_ASSERT(a_valid_flag, !out_valid_reg || (out_data_reg[7] == (out_data_reg[6:3] == ERR_OK)), "valid flag disagrees with error code")
    `APDUCC_ASSERT(a_err_no_case, !out_valid_reg || out_data_reg[6:3] == ERR_OK || out_data_reg[2:0] == CASE_NONE, "case set on error verdict")
    `APDUCC_ASSERT_NEXT(a_last_clears, in_xfer && s_tlast, out_valid_reg && count_reg == '0, "last byte did not issue verdict and clear count")
    `APDUCC_ASSERT_NEXT(a_count_step, in_xfer && !s_tlast && count_reg != COUNT_MAX, count_reg == $past(count_reg) + 17'd1, "byte count did not advance")

endmodule
